// ----- hw/rtl/rswc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the radio scan walk controller.
// No dependencies; imported by every module of the block.
package rswc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int POS_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CHAN_W      = 16;
  localparam int OUTQ_DEPTH  = 3;
  localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // beat modes
  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_APPEND = 3'd1,
    MODE_CLEAR  = 3'd2,
    MODE_START  = 3'd3,
    MODE_STOP   = 3'd4,
    MODE_JUMP   = 3'd5,
    MODE_SPARE6 = 3'd6,
    MODE_SPARE7 = 3'd7
  } mode_t;

  // result events
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_ENTRY  = 3'd1,
    EV_EMPTY  = 3'd2,
    EV_LANDED = 3'd3,
    EV_HANG   = 3'd4
  } scan_event_t;

  // reported phase codes
  typedef enum logic [2:0] {
    PC_IDLE   = 3'd0,
    PC_WALK   = 3'd1,
    PC_DECODE = 3'd2,
    PC_LANDED = 3'd3,
    PC_HANG   = 3'd4
  } phase_code_t;

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DWELL,
    CFG_DECODE,
    CFG_HANG,
    CFG_GUARD,
    CFG_ILV
  } cfg_reg_t;

  // one stored table entry
  typedef struct packed {
    logic              follow;
    logic              tone_coded;
    logic [CHAN_W-1:0] channel;
  } entry_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic              sql_open;
    logic              tone_ok;
    logic [CHAN_W-1:0] entry_channel;
    logic              entry_tone_coded;
    logic              entry_follow;
    logic [POS_W-1:0]  jump_position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        scan_event;
    logic [2:0]        scan_phase;
    logic [POS_W-1:0]  current_position;
    logic [CHAN_W-1:0] current_channel;
    logic [CNT_W-1:0]  entry_count;
  } out_item_t;

endpackage

// ----- hw/rtl/rswc_table.sv -----
`timescale 1ns / 1ps
// Entry table: one write port, one registered read port, same-address bypass.
// Depends on rswc_pkg.
module rswc_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        we,
  input  logic [rswc_pkg::POS_W-1:0]  waddr,
  input  rswc_pkg::entry_t            wdata,
  input  logic [rswc_pkg::POS_W-1:0]  raddr,
  output rswc_pkg::entry_t            rdata
);
  import rswc_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_r;
  entry_t wd_r;
  logic   fwd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
    wd_r <= wdata;
  end

  // write and read on the same entry in one cycle: hand over the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= we && (waddr == raddr);
    end
  end

  assign rdata = fwd_r ? wd_r : rd_r;

endmodule

// ----- hw/rtl/rswc_outq.sv -----
`timescale 1ns / 1ps
// Small result queue in front of the output port.
// Depends on rswc_pkg.
module rswc_outq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  rswc_pkg::out_item_t             push_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rswc_pkg::out_item_t             out_data,
  output logic [rswc_pkg::OUTQ_CNT_W-1:0] level
);
  import rswc_pkg::*;

  out_item_t               slot_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wp_r, rp_r;
  logic [OUTQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                    pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[rp_r];
  assign level     = cnt_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + OUTQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - OUTQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wp_r + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rp_r + OUTQ_PTR_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/radio_scan_walk_controller.sv -----
`timescale 1ns / 1ps
// Top level of the radio scan walk controller.
// Depends on rswc_pkg, rswc_table and rswc_outq.
//
// Takes one beat per clock while in_stall is low: a 10 ms tick or a
// table/control command (append, clear, start, stop, jump), and returns
// exactly one result beat for each. The entry table lives in a 64 x 18
// synchronous RAM that is read every cycle at the position the walk will
// hold next, so the entry under the walk pointer is on the read port
// whenever the following beat needs it; an append to that very entry is
// bypassed. Result beats pass through a three-deep queue, so input keeps
// flowing while the consumer stalls, until three results are waiting (or
// two plus one in flight), at which point in_stall rises. No clearing pass
// after reset: entries past the loaded count are never used. The user
// writes config registers only while idle; the block does not enforce it.
module radio_scan_walk_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rswc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rswc_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [rswc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rswc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rswc_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_WALK   = 5'b00010,
    PH_DECODE = 5'b00100,
    PH_LANDED = 5'b01000,
    PH_HANG   = 5'b10000
  } phase_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] c;
    case (ph)
      PH_IDLE:   c = PC_IDLE;
      PH_WALK:   c = PC_WALK;
      PH_DECODE: c = PC_DECODE;
      PH_LANDED: c = PC_LANDED;
      PH_HANG:   c = PC_HANG;
      default:   c = PC_IDLE;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------- config
  logic [14:0] dwell_r, decode_r, hang_r;
  logic [15:0] guard_r;
  logic [7:0]  ilv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r  <= 15'd5;
      decode_r <= 15'd10;
      hang_r   <= 15'd200;
      guard_r  <= 16'd500;
      ilv_r    <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DWELL:  dwell_r  <= cfg_wdata[14:0];
        CFG_DECODE: decode_r <= cfg_wdata[14:0];
        CFG_HANG:   hang_r   <= cfg_wdata[14:0];
        CFG_GUARD:  guard_r  <= cfg_wdata;
        CFG_ILV:    ilv_r    <= cfg_wdata[7:0];
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              fol_v_r, fol_v_nxt;
  logic [POS_W-1:0]  fol_slot_r, fol_slot_nxt;
  logic [7:0]        ssf_r, ssf_nxt;
  // ssf_r holds a pending value until the new entry's follow flag is read
  logic              ssf_lazy_r, ssf_lazy_nxt;
  phase_t            phase_r, phase_nxt;
  logic [15:0]       cd_r, cd_nxt;
  logic              grd_v_r, grd_v_nxt;
  logic [POS_W-1:0]  grd_slot_r, grd_slot_nxt;
  logic [15:0]       lc_r, lc_nxt;
  logic [2:0]        ev_nxt;

  logic              in_acc;
  entry_t            ent;
  entry_t            cur;
  logic              tbl_we;
  entry_t            tbl_wd;

  assign in_acc = in_valid && !in_stall;

  rswc_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (tbl_we),
    .waddr (count_r[POS_W-1:0]),
    .wdata (tbl_wd),
    .raddr (pos_nxt),
    .rdata (ent)
  );

  // entry under the walk pointer; an empty table reads as an uncoded channel 0
  assign cur = ({1'b0, pos_r} < count_r) ? ent : '0;

  logic [7:0] ssf_eff;
  assign ssf_eff = (ssf_lazy_r && ent.follow) ? 8'd0 : ssf_r;

  // ------------------------------------------------------- next entry choice
  logic [CNT_W-1:0] adv_p1, adv_p2;
  logic [POS_W-1:0] adv_seq, adv_c1, adv_c2, adv_next;
  logic             adv_skip;
  logic [7:0]       ssf_inc;

  always_comb begin
    adv_p1   = {1'b0, pos_r} + CNT_W'(1);
    adv_seq  = (adv_p1 >= count_r) ? '0 : adv_p1[POS_W-1:0];
    adv_c1   = (fol_v_r && (ssf_eff >= ilv_r)) ? fol_slot_r : adv_seq;
    // guarded entry is passed over once
    adv_skip = grd_v_r && (grd_slot_r == adv_c1) && (count_r > CNT_W'(1));
    adv_p2   = {1'b0, adv_c1} + CNT_W'(1);
    adv_c2   = (adv_p2 >= count_r) ? '0 : adv_p2[POS_W-1:0];
    adv_next = adv_skip ? adv_c2 : adv_c1;
    ssf_inc  = (ssf_eff == 8'hFF) ? ssf_eff : ssf_eff + 8'd1;
  end

  // ------------------------------------------------------------- step logic
  logic        fire;
  logic [15:0] cd_dec;
  logic        do_adv;
  logic        keep;
  logic [15:0] lc_inc;
  logic        sq, tone;

  assign fire   = (cd_r <= 16'd1);
  assign cd_dec = fire ? 16'd0 : cd_r - 16'd1;
  assign sq     = in_data.sql_open;
  assign tone   = in_data.tone_ok;
  assign keep   = cur.tone_coded ? (sq && tone) : sq;
  assign lc_inc = (lc_r == 16'hFFFF) ? lc_r : lc_r + 16'd1;

  always_comb begin
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    fol_v_nxt    = fol_v_r;
    fol_slot_nxt = fol_slot_r;
    ssf_nxt      = ssf_eff;
    ssf_lazy_nxt = 1'b0;
    phase_nxt    = phase_r;
    cd_nxt       = cd_r;
    grd_v_nxt    = grd_v_r;
    grd_slot_nxt = grd_slot_r;
    lc_nxt       = lc_r;
    ev_nxt       = EV_NONE;
    do_adv       = 1'b0;
    tbl_we       = 1'b0;
    tbl_wd       = '{follow: in_data.entry_follow, tone_coded: in_data.entry_tone_coded,
                     channel: in_data.entry_channel};

    if (in_acc) begin
      case (in_data.mode)
        MODE_TICK: begin
          case (phase_r)
            PH_WALK: begin
              if (sq) begin
                phase_nxt = PH_DECODE;
                cd_nxt    = {1'b0, decode_r};
              end else begin
                cd_nxt = cd_dec;
                do_adv = fire;
              end
            end
            PH_DECODE: begin
              if (!sq) begin
                cd_nxt = 16'd0;
                do_adv = 1'b1;
              end else begin
                cd_nxt = cd_dec;
                if (fire) begin
                  if (!cur.tone_coded || tone) begin
                    phase_nxt = PH_LANDED;
                    lc_nxt    = 16'd0;
                    ev_nxt    = EV_LANDED;
                  end else begin
                    do_adv = 1'b1;
                  end
                end
              end
            end
            PH_LANDED: begin
              if (!keep) begin
                phase_nxt = PH_HANG;
                cd_nxt    = {1'b0, hang_r};
                ev_nxt    = EV_HANG;
              end else if (!cur.tone_coded) begin
                lc_nxt = lc_inc;
                // carrier held too long: mark for one skip and drop to hang
                if (lc_inc >= guard_r) begin
                  grd_v_nxt    = 1'b1;
                  grd_slot_nxt = pos_r;
                  phase_nxt    = PH_HANG;
                  cd_nxt       = 16'd0;
                  ev_nxt       = EV_HANG;
                end
              end
            end
            PH_HANG: begin
              if (sq && (!cur.tone_coded || tone)) begin
                phase_nxt = PH_LANDED;
                lc_nxt    = 16'd0;
                ev_nxt    = EV_LANDED;
              end else begin
                cd_nxt = cd_dec;
                do_adv = fire;
              end
            end
            default: ;
          endcase
        end
        MODE_APPEND: begin
          if (count_r < CNT_W'(TABLE_DEPTH)) begin
            tbl_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            if (in_data.entry_follow) begin
              fol_v_nxt    = 1'b1;
              fol_slot_nxt = count_r[POS_W-1:0];
            end
          end
        end
        MODE_CLEAR: begin
          count_nxt = '0;
          pos_nxt   = '0;
          fol_v_nxt = 1'b0;
          grd_v_nxt = 1'b0;
        end
        MODE_START: begin
          phase_nxt = PH_WALK;
          cd_nxt    = {1'b0, dwell_r};
          ssf_nxt   = 8'd0;
        end
        MODE_STOP: begin
          phase_nxt = PH_IDLE;
        end
        MODE_JUMP: begin
          if ({1'b0, in_data.jump_position} < count_r) begin
            pos_nxt      = in_data.jump_position;
            phase_nxt    = PH_WALK;
            cd_nxt       = {1'b0, dwell_r};
            // 0 if the target is the follow entry, else 1: settled next cycle
            ssf_nxt      = 8'd1;
            ssf_lazy_nxt = 1'b1;
            grd_v_nxt    = 1'b0;
          end
        end
        default: ;
      endcase

      if (do_adv) begin
        if (count_r == '0) begin
          phase_nxt = PH_IDLE;
          ev_nxt    = EV_EMPTY;
        end else begin
          pos_nxt      = adv_next;
          if (adv_skip) begin
            grd_v_nxt = 1'b0;
          end
          ssf_nxt      = ssf_inc;
          ssf_lazy_nxt = 1'b1;
          phase_nxt    = PH_WALK;
          cd_nxt       = {1'b0, dwell_r};
          ev_nxt       = EV_ENTRY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pos_r      <= '0;
      fol_v_r    <= 1'b0;
      fol_slot_r <= '0;
      ssf_r      <= '0;
      ssf_lazy_r <= 1'b0;
      phase_r    <= PH_IDLE;
      cd_r       <= '0;
      grd_v_r    <= 1'b0;
      grd_slot_r <= '0;
      lc_r       <= '0;
    end else begin
      count_r    <= count_nxt;
      pos_r      <= pos_nxt;
      fol_v_r    <= fol_v_nxt;
      fol_slot_r <= fol_slot_nxt;
      ssf_r      <= ssf_nxt;
      ssf_lazy_r <= ssf_lazy_nxt;
      phase_r    <= phase_nxt;
      cd_r       <= cd_nxt;
      grd_v_r    <= grd_v_nxt;
      grd_slot_r <= grd_slot_nxt;
      lc_r       <= lc_nxt;
    end
  end

  // ------------------------------------------------------- result assembly
  // The channel of the new position is on the RAM port in the next cycle, with the s1 stage.
  logic             s1_v_r;
  logic [2:0]       s1_ev_r, s1_ph_r;
  logic [POS_W-1:0] s1_pos_r;
  logic [CNT_W-1:0] s1_cnt_r;
  out_item_t        res;
  logic [OUTQ_CNT_W-1:0] q_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ev_r  <= ev_nxt;
      s1_ph_r  <= phase_code(phase_nxt);
      s1_pos_r <= pos_nxt;
      s1_cnt_r <= count_nxt;
    end
  end

  assign res = '{scan_event: s1_ev_r, scan_phase: s1_ph_r, current_position: s1_pos_r,
                 current_channel: cur.channel, entry_count: s1_cnt_r};

  rswc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_v_r),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .level     (q_level)
  );

  // room must remain for the beat already in flight
  assign in_stall = (q_level == OUTQ_CNT_W'(OUTQ_DEPTH)) ||
                    ((q_level == OUTQ_CNT_W'(OUTQ_DEPTH - 1)) && s1_v_r);

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for radio_scan_walk_controller: queue-fed driver, clocked
// monitor and an in-bench scan predictor. Depends on rswc_pkg and the RTL only.
module tb;
  import rswc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  radio_scan_walk_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Scan predictor: own copy of the table, walk state and registers
  // ---------------------------------------------------------------------------
  entry_t      scan_tbl [TABLE_DEPTH];
  int          tbl_count;
  int          walk_pos;
  bit          follow_ok;
  int          follow_at;
  int          steps_walked;
  phase_code_t walk_phase;
  int          timer;
  bit          guard_ok;
  int          guard_at;
  int          open_ticks;

  int dwell_ticks, decode_hold_ticks, hang_ticks, csq_guard_ticks, follow_interleave;

  // tallies for the closing summary
  int n_landed, n_hang, n_empty, n_guard_skips, n_full_drops, n_beats, n_settings;

  function automatic entry_t cur_entry();
    if (tbl_count == 0 || walk_pos >= tbl_count) return '0;
    return scan_tbl[walk_pos];
  endfunction

  // fires when the countdown is at one or below; then it parks at zero
  function automatic bit timer_expired();
    if (timer <= 1) begin
      timer = 0;
      return 1'b1;
    end
    timer--;
    return 1'b0;
  endfunction

  function automatic scan_event_t walk_next();
    int nxt;
    if (tbl_count == 0) begin
      walk_phase = PC_IDLE;
      return EV_EMPTY;
    end
    if (follow_ok && steps_walked >= follow_interleave) nxt = follow_at;
    else nxt = (walk_pos + 1) % tbl_count;
    // guarded carrier-squelch entry is passed over once
    if (guard_ok && guard_at == nxt && tbl_count > 1) begin
      guard_ok = 1'b0;
      nxt = (nxt + 1) % tbl_count;
      n_guard_skips++;
    end
    walk_pos = nxt;
    if (scan_tbl[nxt].follow) steps_walked = 0;
    else if (steps_walked < 255) steps_walked++;
    walk_phase = PC_WALK;
    timer = dwell_ticks;
    return EV_ENTRY;
  endfunction

  function automatic scan_event_t scan_tick(logic sq, logic tone);
    scan_event_t ev;
    bit coded;
    bit keep;
    ev = EV_NONE;
    coded = cur_entry().tone_coded;
    case (walk_phase)
      PC_WALK: begin
        if (sq) begin
          walk_phase = PC_DECODE;
          timer = decode_hold_ticks;
        end else if (timer_expired()) begin
          ev = walk_next();
        end
      end
      PC_DECODE: begin
        if (!sq) begin
          timer = 0;
          ev = walk_next();
        end else if (timer_expired()) begin
          if (!coded || tone) begin
            walk_phase = PC_LANDED;
            open_ticks = 0;
            ev = EV_LANDED;
          end else begin
            ev = walk_next();
          end
        end
      end
      PC_LANDED: begin
        keep = coded ? (sq && tone) : sq;
        if (!keep) begin
          walk_phase = PC_HANG;
          timer = hang_ticks;
          ev = EV_HANG;
        end else if (!coded) begin
          if (open_ticks < 16'hFFFF) open_ticks++;
          if (open_ticks >= csq_guard_ticks) begin
            guard_ok = 1'b1;
            guard_at = walk_pos;
            walk_phase = PC_HANG;
            timer = 0;
            ev = EV_HANG;
          end
        end
      end
      PC_HANG: begin
        if (sq && (!coded || tone)) begin
          walk_phase = PC_LANDED;
          open_ticks = 0;
          ev = EV_LANDED;
        end else if (timer_expired()) begin
          ev = walk_next();
        end
      end
      default: ;
    endcase
    return ev;
  endfunction

  function automatic out_item_t scan_step(in_item_t it);
    out_item_t   res;
    scan_event_t ev;
    ev = EV_NONE;
    case (it.mode)
      MODE_TICK: ev = scan_tick(it.sql_open, it.tone_ok);
      MODE_APPEND: begin
        if (tbl_count < TABLE_DEPTH) begin
          scan_tbl[tbl_count] = '{follow: it.entry_follow, tone_coded: it.entry_tone_coded,
                                  channel: it.entry_channel};
          if (it.entry_follow) begin
            follow_ok = 1'b1;
            follow_at = tbl_count;
          end
          tbl_count++;
        end else begin
          n_full_drops++;
        end
      end
      MODE_CLEAR: begin
        tbl_count = 0;
        walk_pos  = 0;
        follow_ok = 1'b0;
        guard_ok  = 1'b0;
      end
      MODE_START: begin
        walk_phase   = PC_WALK;
        timer        = dwell_ticks;
        steps_walked = 0;
      end
      MODE_STOP: walk_phase = PC_IDLE;
      MODE_JUMP: begin
        if (it.jump_position < tbl_count) begin
          walk_pos     = int'(it.jump_position);
          walk_phase   = PC_WALK;
          timer        = dwell_ticks;
          steps_walked = scan_tbl[walk_pos].follow ? 0 : 1;
          guard_ok     = 1'b0;
        end
      end
      default: ;
    endcase
    case (ev)
      EV_LANDED: n_landed++;
      EV_HANG:   n_hang++;
      EV_EMPTY:  n_empty++;
      default: ;
    endcase
    res.scan_event       = ev;
    res.scan_phase       = walk_phase;
    res.current_position = walk_pos[POS_W-1:0];
    res.current_channel  = cur_entry().channel;
    res.entry_count      = tbl_count[CNT_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pending beats go out in bursts with random gaps between them
  // ---------------------------------------------------------------------------
  in_item_t  pending_beats [$];
  out_item_t expected_results [$];
  bit beat_taken = 1'b0;
  int burst_left = 1;
  int gap_left   = 0;
  int errors     = 0;
  int results_seen = 0;
  int queued_beats = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !beat_taken) begin
      // stalled: beat stays on the bus unchanged
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_beats.size() > 0) begin
      in_valid <= 1'b1;
      in_data  <= pending_beats.pop_front();
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        // about a quarter of bursts run straight into the next one
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // input acceptance: the predictor runs here, once per accepted beat
  always @(posedge clk) begin
    beat_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(scan_step(in_data));
      n_beats++;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, plus two long hold-offs that should back
  // the block up until in_stall rises
  // ---------------------------------------------------------------------------
  int stall_style = 0;
  int style_left  = 0;
  int hold_left   = 0;
  int holds_done  = 0;
  bit alt_bit     = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < 2 && results_seen >= 300 + holds_done * 350) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      alt_bit = ~alt_bit;
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 20);
        2: out_stall <= ($urandom_range(0, 99) < 60);
        default: out_stall <= alt_bit;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.scan_event !== want.scan_event) begin
          $error("scan_event expected %0d got %0d", want.scan_event, out_data.scan_event);
          errors++;
        end
        if (out_data.scan_phase !== want.scan_phase) begin
          $error("scan_phase expected %0d got %0d", want.scan_phase, out_data.scan_phase);
          errors++;
        end
        if (out_data.current_position !== want.current_position) begin
          $error("current_position expected %0d got %0d",
                 want.current_position, out_data.current_position);
          errors++;
        end
        if (out_data.current_channel !== want.current_channel) begin
          $error("current_channel expected %h got %h",
                 want.current_channel, out_data.current_channel);
          errors++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count expected %0d got %0d", want.entry_count, out_data.entry_count);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no beat moving on either channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // all fields random; the mode picks which of them matter
  function automatic in_item_t noise_beat(mode_t mode);
    in_item_t it;
    it.mode             = mode;
    it.sql_open         = 1'($urandom_range(0, 1));
    it.tone_ok          = 1'($urandom_range(0, 1));
    it.entry_channel    = CHAN_W'($urandom_range(0, 16'hFFFF));
    it.entry_tone_coded = 1'($urandom_range(0, 1));
    it.entry_follow     = 1'($urandom_range(0, 1));
    it.jump_position    = POS_W'($urandom_range(0, TABLE_DEPTH - 1));
    return it;
  endfunction

  task automatic queue_beat(in_item_t it);
    pending_beats.push_back(it);
    queued_beats++;
  endtask

  task automatic queue_tick(logic sq, logic tone);
    in_item_t it;
    it = noise_beat(MODE_TICK);
    it.sql_open = sq;
    it.tone_ok  = tone;
    queue_beat(it);
  endtask

  task automatic queue_append(logic [CHAN_W-1:0] chan, logic coded, logic follow);
    in_item_t it;
    it = noise_beat(MODE_APPEND);
    it.entry_channel    = chan;
    it.entry_tone_coded = coded;
    it.entry_follow     = follow;
    queue_beat(it);
  endtask

  task automatic queue_jump(int pos);
    in_item_t it;
    it = noise_beat(MODE_JUMP);
    it.jump_position = POS_W'(pos);
    queue_beat(it);
  endtask

  // a table load: usually cleared first, then a handful of entries and a start or a jump
  task automatic queue_rebuild(int max_entries);
    int n;
    if ($urandom_range(0, 3) != 0) queue_beat(noise_beat(MODE_CLEAR));
    n = $urandom_range(1, max_entries);
    repeat (n) queue_append(CHAN_W'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 9) < 4,
                            $urandom_range(0, 9) < 2);
    if ($urandom_range(0, 1)) queue_beat(noise_beat(MODE_START));
    else queue_jump($urandom_range(0, n - 1));
  endtask

  // fill to the brim, one append past full, then walk from the last slot
  task automatic queue_full_table();
    queue_beat(noise_beat(MODE_CLEAR));
    repeat (TABLE_DEPTH + 1)
      queue_append(CHAN_W'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 19) == 0);
    queue_jump(TABLE_DEPTH - 1);
  endtask

  // a squelch episode of a few ticks
  task automatic queue_episode();
    int len;
    int style;
    len   = $urandom_range(1, 12);
    style = $urandom_range(0, 9);
    repeat (len) begin
      case (style)
        0, 1, 2, 3: queue_tick(1'b0, 1'($urandom_range(0, 1)));
        4, 5, 6:    queue_tick(1'b1, $urandom_range(0, 9) != 0);
        7:          queue_tick(1'b1, $urandom_range(0, 9) == 0);
        default:    queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  task automatic queue_traffic(int n_items, bit with_full);
    int target;
    int r;
    target = queued_beats + n_items;
    if (with_full) queue_full_table();
    while (queued_beats < target) begin
      r = $urandom_range(0, 99);
      if (r < 12) queue_rebuild(10);
      else if (r < 14) queue_full_table();
      else if (r < 22) begin
        case ($urandom_range(0, 6))
          0: queue_beat(noise_beat(MODE_STOP));
          1: queue_beat(noise_beat(MODE_START));
          2: queue_jump($urandom_range(0, TABLE_DEPTH - 1));
          3: queue_beat(noise_beat(MODE_SPARE6));
          4: queue_beat(noise_beat(MODE_SPARE7));
          5: queue_beat(noise_beat(MODE_APPEND));
          default: if ($urandom_range(0, 3) == 0) queue_beat(noise_beat(MODE_CLEAR));
        endcase
      end else begin
        queue_episode();
      end
    end
  endtask

  // sender holds off until every outstanding result has come back;
  // checked at the rising edge, when the driver's last update has settled
  task automatic wait_quiet();
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_DWELL:  dwell_ticks       = value & 16'h7FFF;
      CFG_DECODE: decode_hold_ticks = value & 16'h7FFF;
      CFG_HANG:   hang_ticks        = value & 16'h7FFF;
      CFG_GUARD:  csq_guard_ticks   = value & 16'hFFFF;
      CFG_ILV:    follow_interleave = value & 16'h00FF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(int dwell, int hold, int hang, int guard, int interleave);
    write_reg(CFG_DWELL, dwell);
    write_reg(CFG_DECODE, hold);
    write_reg(CFG_HANG, hang);
    write_reg(CFG_GUARD, guard);
    write_reg(CFG_ILV, interleave);
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // predictor reset state and register defaults
    tbl_count = 0; walk_pos = 0; follow_ok = 0; follow_at = 0; steps_walked = 0;
    walk_phase = PC_IDLE; timer = 0; guard_ok = 0; guard_at = 0; open_ticks = 0;
    dwell_ticks = 5; decode_hold_ticks = 10; hang_ticks = 200;
    csq_guard_ticks = 500; follow_interleave = 8;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed opening, short timers so every state is visited quickly
    apply_setting(2, 2, 3, 3, 2);
    queue_tick(1'b1, 1'b1);                 // tick while idle does nothing
    queue_beat(noise_beat(MODE_START));     // start on an empty table
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b0);                 // dwell runs out: empty table event
    queue_append(16'hFFFF, 1'b1, 1'b1);     // coded follow entry at slot 0
    queue_append(16'h0000, 1'b0, 1'b0);
    queue_append(16'h8001, 1'b0, 1'b0);
    queue_jump(TABLE_DEPTH - 1);            // beyond the count: ignored
    queue_jump(1);
    queue_tick(1'b1, 1'b0);                 // squelch opens: decode
    queue_tick(1'b1, 1'b0);
    queue_tick(1'b1, 1'b0);                 // uncoded entry lands without tone
    repeat (3) queue_tick(1'b1, 1'b0);      // held open past the guard: hang
    queue_tick(1'b0, 1'b0);                 // walks on
    queue_tick(1'b0, 1'b1);
    queue_tick(1'b0, 1'b1);                 // interleave reached: follow entry
    repeat (3) queue_tick(1'b1, 1'b0);      // coded, no tone: skips guarded slot
    queue_beat(noise_beat(MODE_SPARE6));
    queue_beat(noise_beat(MODE_SPARE7));
    queue_beat(noise_beat(MODE_STOP));
    queue_beat(noise_beat(MODE_CLEAR));
    wait_quiet();

    // random traffic over a spread of register settings, extremes included
    apply_setting($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                  $urandom_range(1, 4), $urandom_range(1, 4));
    queue_traffic(250, 1'b1);
    wait_quiet();

    apply_setting(1, 1, 1, 1, 1);
    queue_traffic(150, 1'b0);
    wait_quiet();

    apply_setting($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(2, 8),
                  $urandom_range(2, 8), $urandom_range(2, 8));
    queue_traffic(200, 1'b0);
    wait_quiet();

    // timers at their maxima: only squelch-driven and commanded moves happen here
    apply_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 8'hFF);
    queue_traffic(80, 1'b0);
    wait_quiet();

    apply_setting($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 10),
                  $urandom_range(1, 12), $urandom_range(1, 6));
    queue_traffic(200, 1'b0);

    wait_quiet();
    repeat (8) @(posedge clk);

    $display("covered %0d beats over %0d register settings, %0d long receiver hold-offs",
             n_beats, n_settings, holds_done);
    $display("events: %0d landed, %0d hang, %0d empty, %0d guard skips, %0d full-table drops",
             n_landed, n_hang, n_empty, n_guard_skips, n_full_drops);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
